// ===== hw/rtl/bfdh_pkg.sv =====
package bfdh_pkg;

  localparam int unsigned BitCountW  = 17;
  localparam int unsigned HashCountW = 5;
  localparam int unsigned HashW      = 64;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [HashW-1:0] FnvBasis   = 64'hCBF29CE484222325;
  localparam logic [8:0]       FnvPrimeLo = 9'h1B3;
  localparam int unsigned      FnvShift   = 40;
  localparam logic [HashW-1:0] DjbStart   = 64'd5381;

  localparam logic [CfgIdxW-1:0] RegBitCount  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHashCount = 2'd1;

  localparam logic KindAdd   = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [HashW-1:0]     dividend;
    logic [BitCountW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic                 done;
    logic [BitCountW-1:0] rem;
  } rem_rsp_t;

endpackage

// ===== hw/rtl/bfdh_rem.sv =====
module bfdh_rem
  import bfdh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(HashW + 1);

  logic [HashW-1:0]     num_q, num_d;
  logic [BitCountW-1:0] div_q, div_d;
  logic [BitCountW-1:0] rem_q, rem_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [BitCountW:0]   trial;

  // one restoring step per cycle, msb first
  always_comb begin
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[HashW-1]};
    if (req_i.start) begin
      num_d = req_i.dividend;
      div_d = req_i.divisor;
      rem_d = '0;
      cnt_d = CntW'(HashW);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = BitCountW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[BitCountW-1:0];
      end
      num_d = {num_q[HashW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/bfdh_store.sv =====
module bfdh_store #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic             wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] addr_i,
  output logic             rd_data_o
);

  logic mem_q [Depth];
  logic rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hw/rtl/bloom_filter_double_hash_top.sv =====
// channel | signals                                  | direction
// input   | in_valid_i/in_ready_o, kind, key_byte,   | in
//         | has_byte, last_byte                      |
// output  | out_valid_o/out_ready_i, answer_kind,    | out
//         | present, items_added                     |
// config  | cfg_valid_i/cfg_ready_o, index, data     | in
// a byte that is not last is taken in the idle state; after a last transfer the block is busy
// with up to k hash positions (all k on an add), k the effective hash count, each one computed by
// the shared 64-step bit-serial remainder unit
// a query stops at the first clear bit
// after reset a clearing pass writes MAX_BITS entries, one per cycle, before input is taken
// the result sits in an output register; a stalled output holds the block in its last step
module bloom_filter_double_hash_top
  import bfdh_pkg::*;
#(
  parameter int unsigned MAX_BITS   = 65536,
  parameter int unsigned MAX_HASHES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [7:0]           key_byte_i,
  input  logic                 has_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 answer_kind_o,
  output logic                 present_o,
  output logic [31:0]          items_added_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [BitCountW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_BITS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_DIV, ST_CHECK, ST_RESP
  } state_e;

  state_e                state_q;
  logic [BitCountW-1:0]  bit_count_q;
  logic [HashCountW-1:0] hash_count_q;
  logic [HashW-1:0]      fnv_q, djb_q, pos_q, step_q;
  logic [HashW-1:0]      fnv_x, fnv_next, djb_next;
  logic [HashCountW-1:0] idx_q;
  logic                  kind_q, present_q;
  logic [31:0]           added_q;
  logic [AddrW-1:0]      clr_q;
  logic                  out_valid_q, out_kind_q, out_present_q;
  logic [31:0]           out_items_q;

  logic [BitCountW-1:0]  m_eff;
  logic [HashCountW-1:0] k_eff;
  rem_req_t              rem_req;
  rem_rsp_t              rem_rsp;
  logic [31:0]           rem_ext;
  logic                  st_wr, st_rd, st_wdata, st_rdata;
  logic [AddrW-1:0]      st_addr;
  logic                  in_xfer;

  always_comb begin
    if (bit_count_q == '0) begin
      m_eff = BitCountW'(1);
    end else if (32'(bit_count_q) > 32'(MAX_BITS)) begin
      m_eff = BitCountW'(MAX_BITS);
    end else begin
      m_eff = bit_count_q;
    end
    if (32'(hash_count_q) > 32'(MAX_HASHES)) begin
      k_eff = HashCountW'(MAX_HASHES);
    end else begin
      k_eff = hash_count_q;
    end
  end

  assign fnv_x    = fnv_q ^ {56'd0, key_byte_i};
  assign fnv_next = (fnv_x << FnvShift) + (fnv_x * {55'd0, FnvPrimeLo});
  assign djb_next = ((djb_q << 5) + djb_q) ^ {56'd0, key_byte_i};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign rem_req.start    = (state_q == ST_LOAD) && (idx_q != k_eff);
  assign rem_req.dividend = pos_q;
  assign rem_req.divisor  = m_eff;

  bfdh_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign rem_ext  = 32'(rem_rsp.rem);
  assign st_wr    = (state_q == ST_CLEAR) ||
                    ((state_q == ST_DIV) && rem_rsp.done && (kind_q == KindAdd));
  assign st_rd    = (state_q == ST_DIV) && rem_rsp.done && (kind_q == KindQuery);
  assign st_wdata = (state_q != ST_CLEAR);
  assign st_addr  = (state_q == ST_CLEAR) ? clr_q : rem_ext[AddrW-1:0];

  bfdh_store #(
    .Depth (MAX_BITS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr),
    .wr_data_i (st_wdata),
    .rd_en_i   (st_rd),
    .addr_i    (st_addr),
    .rd_data_o (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      bit_count_q   <= BitCountW'(65536);
      hash_count_q  <= HashCountW'(7);
      fnv_q         <= FnvBasis;
      djb_q         <= DjbStart;
      added_q       <= '0;
      clr_q         <= '0;
      idx_q         <= '0;
      kind_q        <= KindAdd;
      present_q     <= 1'b1;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KindAdd;
      out_present_q <= 1'b1;
      out_items_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegBitCount:  bit_count_q  <= cfg_data_i;
          RegHashCount: hash_count_q <= cfg_data_i[HashCountW-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(MAX_BITS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (last_byte_i) begin
              pos_q     <= has_byte_i ? fnv_next : fnv_q;
              step_q    <= has_byte_i ? djb_next : djb_q;
              fnv_q     <= FnvBasis;
              djb_q     <= DjbStart;
              kind_q    <= kind_i;
              idx_q     <= '0;
              present_q <= 1'b1;
              state_q   <= ST_LOAD;
            end else if (has_byte_i) begin
              fnv_q <= fnv_next;
              djb_q <= djb_next;
            end
          end
        end
        ST_LOAD: begin
          state_q <= (idx_q == k_eff) ? ST_RESP : ST_DIV;
        end
        ST_DIV: begin
          if (rem_rsp.done) begin
            if (kind_q == KindAdd) begin
              pos_q   <= pos_q + step_q;
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (!st_rdata) begin
            present_q <= 1'b0;
            state_q   <= ST_RESP;
          end else begin
            pos_q   <= pos_q + step_q;
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_kind_q    <= kind_q;
            out_present_q <= present_q;
            if (kind_q == KindAdd) begin
              added_q     <= added_q + 1'b1;
              out_items_q <= added_q + 1'b1;
            end else begin
              out_items_q <= added_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign answer_kind_o = out_kind_q;
  assign present_o     = out_present_q;
  assign items_added_o = out_items_q;

endmodule
